// ===== src/gqr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gqr_pkg
// Shared widths and the constant table of -log2(k/256) used by the code search.
// ----------------------------------------------------------------------------
package gqr_pkg;

    localparam int LEVEL_W = 24;          // width of one channel level
    localparam int GAMMA_W = 16;          // gamma register, unsigned Q8.8
    localparam int CODE_W  = 8;           // output byte
    localparam int MW      = 32;          // normalized mantissa width, Q1.31
    localparam int LF      = 28;          // fraction bits of the logarithm
    localparam int IPW     = 5;           // integer bits of the logarithm
    localparam int LW      = IPW + LF;    // logarithm width
    localparam int PW      = GAMMA_W + LW; // gamma times table entry
    localparam int SEARCH_STEPS = CODE_W;
    localparam int CODES   = 1 << CODE_W;

    typedef logic [LW-1:0] nlog_table_t [CODES];

    // -log2(k/256) in Q5.LF, computed with the same squaring steps as the datapath
    function automatic nlog_table_t build_nlog();
        nlog_table_t tab;
        logic [63:0] m;
        logic [63:0] sq;
        logic [LF-1:0] frac;
        int p;
        tab[0] = '1;
        for (int k = 1; k < CODES; k++) begin
            p = 0;
            for (int i = 0; i < CODE_W; i++) begin
                if (((k >> i) & 1) == 1) p = i;
            end
            m = 64'(k) << (MW - 1 - p);
            frac = '0;
            for (int j = 0; j < LF; j++) begin
                sq = m * m;
                if (sq[63]) begin
                    frac[LF-1-j] = 1'b1;
                    m = {32'd0, sq[63:32]};
                end else begin
                    m = {32'd0, sq[62:31]};
                end
            end
            tab[k] = LW'(((64'(CODE_W - p)) << LF) - 64'(frac));
        end
        return tab;
    endfunction

    localparam nlog_table_t NLOG_TABLE = build_nlog();

endpackage

// ===== src/gqr_channel.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gqr_channel
// One color channel: clamp, log2 by repeated squaring, code search by compare.
// ----------------------------------------------------------------------------
module gqr_channel
    import gqr_pkg::*;
#(
    parameter int LEVEL_FRAC_BITS = 16
)
(
    input  logic                clk,
    input  logic                en,
    input  logic [GAMMA_W-1:0]  gamma,
    input  logic [LEVEL_W-1:0]  level,
    output logic [CODE_W-1:0]   code
);

    localparam logic [LEVEL_W:0] ONE = (LEVEL_W+1)'(1) << LEVEL_FRAC_BITS;

    // classify stage
    logic [LEVEL_W-1:0] v_reg;
    logic               zero_c_reg;
    logic               sat_c_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg      <= level;
            zero_c_reg <= level[LEVEL_W-1] || (level == '0);
            sat_c_reg  <= !level[LEVEL_W-1] && ({1'b0, level} >= ONE);
        end
    end

    // normalize: find leading one, scale mantissa into [1,2)
    logic [IPW-1:0] lead;
    always_comb
    begin
        lead = '0;
        for (int i = 0; i < LEVEL_W; i++)
        begin
            if (v_reg[i]) lead = IPW'(i);
        end
    end

    logic [MW-1:0]  m_reg    [LF+1];
    logic [LF-1:0]  frac_reg [LF+1];
    logic [IPW-1:0] ip_reg   [LF+1];
    logic           zero_reg [LF+1];
    logic           sat_reg  [LF+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg[0]    <= MW'(MW'(v_reg) << (IPW'(MW - 1) - lead));
            frac_reg[0] <= '0;
            ip_reg[0]   <= IPW'(LEVEL_FRAC_BITS) - lead;
            zero_reg[0] <= zero_c_reg;
            sat_reg[0]  <= sat_c_reg;
        end
    end

    // one fraction bit per stage: square, bit is set when the square reaches 2
    for (genvar j = 0; j < LF; j++) begin : g_sq
        logic [2*MW-1:0] sq;
        logic [MW-1:0]   m_next;
        logic [LF-1:0]   frac_next;
        always_comb
        begin
            sq        = m_reg[j] * m_reg[j];
            frac_next = frac_reg[j];
            if (sq[2*MW-1])
            begin
                m_next              = sq[2*MW-1 -: MW];
                frac_next[LF-1-j]   = 1'b1;
            end
            else
            begin
                m_next = sq[2*MW-2 -: MW];
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                m_reg[j+1]    <= m_next;
                frac_reg[j+1] <= frac_next;
                ip_reg[j+1]   <= ip_reg[j];
                zero_reg[j+1] <= zero_reg[j];
                sat_reg[j+1]  <= sat_reg[j];
            end
        end
    end

    // L = -log2(x); a saturated level gets zero so every code passes
    logic [LW-1:0] l_reg;
    logic          lz_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            l_reg  <= sat_reg[LF] ? '0 : ({ip_reg[LF], {LF{1'b0}}} - {{IPW{1'b0}}, frac_reg[LF]});
            lz_reg <= zero_reg[LF];
        end
    end

    // binary search: code k passes when 256*L <= gamma * -log2(k/256)
    logic [CODE_W-1:0] lo_reg   [1:SEARCH_STEPS];
    logic [CODE_W-1:0] hi_reg   [1:SEARCH_STEPS];
    logic [LW-1:0]     ls_reg   [1:SEARCH_STEPS];
    logic              zs_reg   [1:SEARCH_STEPS];

    for (genvar s = 0; s < SEARCH_STEPS; s++) begin : g_search
        logic [CODE_W-1:0] lo_cur;
        logic [CODE_W-1:0] hi_cur;
        logic [LW-1:0]     ls_cur;
        logic              zs_cur;
        logic [CODE_W:0]   sum;
        logic [CODE_W-1:0] mid;
        logic [PW-1:0]     prod;
        logic [PW-1:0]     lhs;
        logic              pass;

        // the first step starts from the full code range
        if (s == 0) begin : g_first
            assign lo_cur = '0;
            assign hi_cur = '1;
            assign ls_cur = l_reg;
            assign zs_cur = lz_reg;
        end
        else begin : g_next
            assign lo_cur = lo_reg[s];
            assign hi_cur = hi_reg[s];
            assign ls_cur = ls_reg[s];
            assign zs_cur = zs_reg[s];
        end

        always_comb
        begin
            sum  = {1'b0, lo_cur} + {1'b0, hi_cur} + (CODE_W+1)'(1);
            mid  = sum[CODE_W:1];
            prod = PW'(gamma) * PW'(NLOG_TABLE[mid]);
            lhs  = PW'({ls_cur, {CODE_W{1'b0}}});
            pass = !zs_cur && (lhs <= prod);
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                lo_reg[s+1] <= pass ? mid : lo_cur;
                hi_reg[s+1] <= pass ? hi_cur : mid - CODE_W'(1);
                ls_reg[s+1] <= ls_cur;
                zs_reg[s+1] <= zs_cur;
            end
        end
    end

    assign code = lo_reg[SEARCH_STEPS];

endmodule

// ===== src/gamma_quantize_rgb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gamma_quantize_rgb
// Per-pixel gamma correction of three fixed-point levels to 8-bit codes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid / in_stall with red_level, green_level, blue_level
//   (signed, LEVEL_FRAC_BITS fraction bits) and last_pixel. A request is taken
//   at a clock edge with in_valid high and in_stall low.
//   Output channel: out_valid / out_stall with red_byte, green_byte, blue_byte
//   and last_pixel_out, the flag copied from the matching input request.
//   Throughput: one pixel per clock unless the receiver stalls. The pipeline
//   has the classify and normalize stages, one squaring stage per log2
//   fraction bit, a log stage and eight compare stages of the code search.
//   Gamma (unsigned Q8.8) is written through gamma_we / gamma_wdata; write it
//   only while no request is in flight. Reset empties the pipeline and sets
//   gamma to 1.0.
//   When the receiver stalls a valid result, the whole pipeline holds and
//   in_stall rises; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module gamma_quantize_rgb
    import gqr_pkg::*;
#(
    parameter int LEVEL_FRAC_BITS = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      gamma_we,
    input  logic [GAMMA_W-1:0]        gamma_wdata,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic signed [LEVEL_W-1:0] red_level,
    input  logic signed [LEVEL_W-1:0] green_level,
    input  logic signed [LEVEL_W-1:0] blue_level,
    input  logic                      last_pixel,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [CODE_W-1:0]         red_byte,
    output logic [CODE_W-1:0]         green_byte,
    output logic [CODE_W-1:0]         blue_byte,
    output logic                      last_pixel_out
);

    // classify + normalize + squaring stages + log stage + search stages
    localparam int DEPTH = LF + 3 + SEARCH_STEPS;
    localparam logic [GAMMA_W-1:0] GAMMA_RESET = GAMMA_W'(256);

    logic [GAMMA_W-1:0] gamma_reg;
    logic [DEPTH-1:0]   valid_reg;
    logic [DEPTH-1:0]   last_reg;
    logic               en;

    // advance everything unless a finished result is held by the receiver
    assign en       = !(valid_reg[DEPTH-1] && out_stall);
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gamma_reg <= GAMMA_RESET;
        end
        else if (gamma_we)
        begin
            gamma_reg <= gamma_wdata;
        end
    end

    // valid bits travel with the data; a bubble enters when no request is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[DEPTH-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            last_reg <= {last_reg[DEPTH-2:0], last_pixel};
        end
    end

    gqr_channel #(.LEVEL_FRAC_BITS(LEVEL_FRAC_BITS)) u_red (
        .clk   (clk),
        .en    (en),
        .gamma (gamma_reg),
        .level (red_level),
        .code  (red_byte)
    );

    gqr_channel #(.LEVEL_FRAC_BITS(LEVEL_FRAC_BITS)) u_green (
        .clk   (clk),
        .en    (en),
        .gamma (gamma_reg),
        .level (green_level),
        .code  (green_byte)
    );

    gqr_channel #(.LEVEL_FRAC_BITS(LEVEL_FRAC_BITS)) u_blue (
        .clk   (clk),
        .en    (en),
        .gamma (gamma_reg),
        .level (blue_level),
        .code  (blue_byte)
    );

    assign out_valid      = valid_reg[DEPTH-1];
    assign last_pixel_out = last_reg[DEPTH-1];

    // a held result freezes pipeline occupancy
    a_hold_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(valid_reg))
        else $error("pipeline moved while output was held");

    // the input side only waits on a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a held result");

    // an accepted request occupies the first stage
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> valid_reg[0])
        else $error("accepted request lost at pipeline entry");

endmodule
